// File: sv/tbdc_pkg.sv
package tbdc_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 32;
    localparam int DEFAULT_TIME_WIDTH  = 32;

    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int CMP_WIDTH     = 32;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CAPACITY = 2'd2;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_WIDTH-1:0] TIMEOUT_RST  = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] CAPACITY_RST = 16'd10;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTRY = 2'd1;
    localparam logic [1:0] EV_EXIT  = 2'd2;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ENTRY,
        OP_EXIT,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_time;
        logic [CFG_WIDTH-1:0] pass_timeout_ms;
        logic [CFG_WIDTH-1:0] capacity_limit;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic        beam_a_pending;
        logic        beam_a_level;
        logic        beam_b_pending;
        logic        beam_b_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_code;
        logic [31:0] entry_total;
        logic [31:0] exit_total;
        logic [30:0] present_count;
        logic        full_flag;
    } out_item_t;

endpackage

// File: sv/tbdc_front.sv
module tbdc_front
    import tbdc_pkg::*;
#(
    parameter int TIME_WIDTH = DEFAULT_TIME_WIDTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     op_valid,
    input  logic     op_ready,
    output op_t      op
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_A_FIRST,
        PH_B_FIRST
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [TIME_WIDTH-1:0] first_time_reg, first_time_next;
    logic [TIME_WIDTH-1:0] last_a_reg, last_b_reg;
    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] debounce, timeout;
    logic                  a_hit, b_hit, timed_out, accept;

    assign s_ready  = op_ready;
    assign op_valid = s_valid;
    assign accept   = s_valid & op_ready;

    assign now      = s_data.now_ms[TIME_WIDTH-1:0];
    assign debounce = TIME_WIDTH'(cfg.debounce_time);
    assign timeout  = TIME_WIDTH'(cfg.pass_timeout_ms);

    // beam counts only when its edge is pending, it reads broken and it is past debounce
    assign a_hit = s_data.beam_a_pending & ~s_data.beam_a_level
                 & ((now - last_a_reg) > debounce);
    assign b_hit = s_data.beam_b_pending & ~s_data.beam_b_level
                 & ((now - last_b_reg) > debounce);
    assign timed_out = (now - first_time_reg) > timeout;

    always_comb begin
        phase_next      = phase_reg;
        first_time_next = first_time_reg;
        op              = OP_NONE;
        if (s_data.kind == KIND_CLEAR) begin
            op = OP_CLEAR;
        end else begin
            case (phase_reg)
                PH_A_FIRST: begin
                    if (b_hit) begin
                        op         = OP_ENTRY;
                        phase_next = PH_IDLE;
                    end else if (timed_out) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_B_FIRST: begin
                    if (a_hit) begin
                        op         = OP_EXIT;
                        phase_next = PH_IDLE;
                    end else if (timed_out) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    // A wins when both beams hit together
                    if (a_hit) begin
                        phase_next      = PH_A_FIRST;
                        first_time_next = now;
                    end else if (b_hit) begin
                        phase_next      = PH_B_FIRST;
                        first_time_next = now;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            first_time_reg <= '0;
            last_a_reg     <= '0;
            last_b_reg     <= '0;
        end else if (accept && s_data.kind == KIND_UPDATE) begin
            phase_reg      <= phase_next;
            first_time_reg <= first_time_next;
            if (a_hit) begin
                last_a_reg <= now;
            end
            if (b_hit) begin
                last_b_reg <= now;
            end
        end
    end

endmodule

// File: sv/tbdc_queue.sv
module tbdc_queue
    import tbdc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  op_t  wr_op,
    output logic rd_valid,
    input  logic rd_ready,
    output op_t  rd_op
);

    op_t        slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_op    = slot_reg[rd_ptr_reg];
    assign push     = wr_valid & wr_ready;
    assign pop      = rd_valid & rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: sv/tbdc_back.sv
module tbdc_back
    import tbdc_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      op_valid,
    output logic      op_ready,
    input  op_t       op,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [COUNT_WIDTH-1:0] entries_reg, exits_reg;
    logic [COUNT_WIDTH-2:0] occ_reg;
    logic                   full_reg;
    logic [1:0]             event_reg;
    logic                   m_valid_reg;
    logic                   take, at_capacity;

    assign op_ready = ~m_valid_reg | m_ready;
    assign take     = op_valid & op_ready;
    assign at_capacity = CMP_WIDTH'(occ_reg) >= CMP_WIDTH'(cfg.capacity_limit);

    assign m_valid              = m_valid_reg;
    assign m_data.event_code    = event_reg;
    assign m_data.entry_total   = 32'(entries_reg);
    assign m_data.exit_total    = 32'(exits_reg);
    assign m_data.present_count = 31'(occ_reg);
    assign m_data.full_flag     = full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= '0;
            exits_reg   <= '0;
            occ_reg     <= '0;
            full_reg    <= 1'b0;
            event_reg   <= EV_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                m_valid_reg <= 1'b1;
                case (op)
                    OP_CLEAR: begin
                        entries_reg <= '0;
                        exits_reg   <= '0;
                        occ_reg     <= '0;
                        full_reg    <= 1'b0;
                        event_reg   <= EV_NONE;
                    end
                    OP_ENTRY: begin
                        entries_reg <= entries_reg + 1'b1;
                        if (!(&occ_reg)) begin
                            occ_reg <= occ_reg + 1'b1;
                        end
                        event_reg <= EV_ENTRY;
                    end
                    OP_EXIT: begin
                        exits_reg <= exits_reg + 1'b1;
                        if (occ_reg != '0) begin
                            occ_reg <= occ_reg - 1'b1;
                        end
                        event_reg <= EV_EXIT;
                    end
                    default: begin
                        // full is refreshed only on transactions without an event
                        full_reg  <= at_capacity;
                        event_reg <= EV_NONE;
                    end
                endcase
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: sv/two_beam_direction_counter.sv
// Two-beam doorway people counter.
// s_ channel: one transaction per sensor sample (timestamp, pending flag and
// pin level for the outer beam A and inner beam B) or a clear command.
// m_ channel: exactly one transaction per input transaction, in order, with
// the event (none, entry, exit), entry and exit totals, occupancy and the
// room-full flag.
// Config port: cfg_we/cfg_index/cfg_wdata write debounce, pass timeout and
// capacity; write only while no transaction is in flight.
// m_valid is registered: an accepted input passes through the two-entry op
// queue register, then the counter stage's output register.
// Throughput: 1 transaction per cycle while m_ready is high, set by the combinational
// trigger qualification in the front stage and the counter update in the back stage.
// Reset (aresetn low, synchronous): counters, phase and timestamps clear and
// the registers return to 50 ms debounce, 1000 ms timeout, capacity 10.
// When m_ready is low the result holds; the queue absorbs two more
// transactions, then s_ready drops until the receiver drains.
module two_beam_direction_counter
    import tbdc_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH,
    parameter int TIME_WIDTH  = DEFAULT_TIME_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data
);

    cfg_t cfg_reg;
    logic front_valid, front_ready, back_valid, back_ready;
    op_t  front_op, back_op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time   <= DEBOUNCE_RST;
            cfg_reg.pass_timeout_ms <= TIMEOUT_RST;
            cfg_reg.capacity_limit  <= CAPACITY_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEBOUNCE: cfg_reg.debounce_time   <= cfg_wdata;
                CFG_TIMEOUT:  cfg_reg.pass_timeout_ms <= cfg_wdata;
                CFG_CAPACITY: cfg_reg.capacity_limit  <= cfg_wdata;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    tbdc_front #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .op_valid (front_valid),
        .op_ready (front_ready),
        .op       (front_op)
    );

    tbdc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_op    (front_op),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_op    (back_op)
    );

    tbdc_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .op_valid (back_valid),
        .op_ready (back_ready),
        .op       (back_op),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
